### rtl/fdsm_pkg.sv
package fdsm_pkg;

  // Opcodes of the input item
  localparam logic [1:0] OP_LOAD_INT  = 2'd0;
  localparam logic [1:0] OP_LOAD_TIME = 2'd1;
  localparam logic [1:0] OP_TICK      = 2'd2;

  // Configuration register indexes
  localparam logic REG_DWELL_TICKS     = 1'b0;
  localparam logic REG_DRIVER_POLARITY = 1'b1;

  // Digit codes
  localparam logic [3:0] CODE_BLANK = 4'd10;
  localparam logic [3:0] CODE_MINUS = 4'd11;
  localparam logic [3:0] CODE_E     = 4'd12;
  localparam logic [3:0] CODE_R     = 4'd13;

  // Value limits
  localparam logic signed [14:0] INT_MAX  = 15'sd9999;
  localparam logic signed [14:0] INT_MIN  = -15'sd999;
  localparam logic [6:0]         PAIR_MAX = 7'd99;

  // Defaults
  localparam int HOLD_WIDTH_DEFAULT  = 24;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // What the back end does with an item
  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_TICK = 2'd1,
    KIND_NOP  = 2'd2
  } item_kind_t;

  // Classified item, without its hold time
  typedef struct packed {
    item_kind_t       kind;
    logic [3:0][3:0]  codes;
    logic             colon;
    logic             status;
  } front_item_t;

  // Segment pattern for a digit code
  function automatic logic [6:0] seg_lookup(input logic [3:0] code);
    logic [6:0] s;
    case (code)
      4'd0:    s = 7'h77;
      4'd1:    s = 7'h44;
      4'd2:    s = 7'h3E;
      4'd3:    s = 7'h6E;
      4'd4:    s = 7'h4D;
      4'd5:    s = 7'h6B;
      4'd6:    s = 7'h7B;
      4'd7:    s = 7'h46;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h4F;
      4'd11:   s = 7'h08;
      4'd12:   s = 7'h3B;
      4'd13:   s = 7'h18;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Constant divisions by reciprocal, exact for values up to 9999
  function automatic logic [13:0] div10(input logic [13:0] v);
    logic [31:0] p;
    p = 32'(v) * 32'd52429;
    return 14'(p >> 19);
  endfunction

  function automatic logic [13:0] div100(input logic [13:0] v);
    logic [31:0] p;
    p = 32'(v) * 32'd5243;
    return 14'(p >> 19);
  endfunction

  function automatic logic [13:0] div1000(input logic [13:0] v);
    logic [31:0] p;
    p = 32'(v) * 32'd8389;
    return 14'(p >> 23);
  endfunction

  function automatic logic [13:0] times10(input logic [13:0] v);
    return (v << 3) + (v << 1);
  endfunction

endpackage

### rtl/fdsm_front.sv
module fdsm_front #(
  parameter int HOLD_WIDTH = fdsm_pkg::HOLD_WIDTH_DEFAULT
) (
  input  logic [1:0]               opcode,
  input  logic signed [14:0]       number,
  input  logic                     align_left,
  input  logic [6:0]               left_pair,
  input  logic [6:0]               right_pair,
  input  logic                     leading_zero,
  input  logic [23:0]              hold_ticks,
  output fdsm_pkg::front_item_t    item,
  output logic [HOLD_WIDTH-1:0]    hold
);

  logic                  neg;
  logic                  int_bad;
  logic [14:0]           mag15;
  logic [13:0]           mag;
  logic [13:0]           q10;
  logic [13:0]           q100;
  logic [13:0]           q1000;
  logic [3:0][3:0]       digs;
  logic [2:0]            nd;
  logic [3:0][3:0]       int_codes;
  logic                  time_bad;
  logic [13:0]           qa;
  logic [13:0]           qb;
  logic [13:0]           a_ext;
  logic [13:0]           b_ext;
  logic [3:0][3:0]       time_codes;
  logic [3:0][3:0]       err_codes;

  assign hold = HOLD_WIDTH'(hold_ticks);

  // Integer: magnitude and decimal digits
  assign neg     = number[14];
  assign int_bad = (number > fdsm_pkg::INT_MAX) || (number < fdsm_pkg::INT_MIN);
  assign mag15   = neg ? 15'(-number) : 15'(number);
  assign mag     = mag15[13:0];
  assign q10     = fdsm_pkg::div10(mag);
  assign q100    = fdsm_pkg::div100(mag);
  assign q1000   = fdsm_pkg::div1000(mag);

  always_comb begin
    logic [13:0] t3;
    logic [13:0] t2;
    logic [13:0] t1;
    t3 = mag - fdsm_pkg::times10(q10);
    t2 = q10 - fdsm_pkg::times10(q100);
    t1 = q100 - fdsm_pkg::times10(q1000);
    digs[0] = q1000[3:0];
    digs[1] = t1[3:0];
    digs[2] = t2[3:0];
    digs[3] = t3[3:0];
  end

  // Count of significant digits
  always_comb begin
    if (mag >= 14'd1000) begin
      nd = 3'd4;
    end else if (mag >= 14'd100) begin
      nd = 3'd3;
    end else if (mag >= 14'd10) begin
      nd = 3'd2;
    end else begin
      nd = 3'd1;
    end
  end

  // Place digits, right or left aligned, minus sign leftmost
  always_comb begin
    logic [2:0] ii;
    logic [2:0] off;
    logic [2:0] rel;
    logic [2:0] src;
    for (int i = 0; i < 4; i++) begin
      ii  = 3'(i);
      off = {2'b00, neg};
      rel = ii - off;
      src = rel + 3'd4 - nd;
      if (align_left) begin
        if (ii >= off && rel < nd) begin
          int_codes[i] = digs[src[1:0]];
        end else begin
          int_codes[i] = fdsm_pkg::CODE_BLANK;
        end
      end else begin
        if (ii >= 3'd4 - nd) begin
          int_codes[i] = digs[i];
        end else begin
          int_codes[i] = fdsm_pkg::CODE_BLANK;
        end
      end
    end
    if (neg) begin
      int_codes[0] = fdsm_pkg::CODE_MINUS;
    end
  end

  // Time pair digits
  assign time_bad = (left_pair > fdsm_pkg::PAIR_MAX) || (right_pair > fdsm_pkg::PAIR_MAX);
  assign a_ext    = {7'b0, left_pair};
  assign b_ext    = {7'b0, right_pair};
  assign qa       = fdsm_pkg::div10(a_ext);
  assign qb       = fdsm_pkg::div10(b_ext);

  always_comb begin
    logic [13:0] ra;
    logic [13:0] rb;
    ra = a_ext - fdsm_pkg::times10(qa);
    rb = b_ext - fdsm_pkg::times10(qb);
    if (left_pair > 7'd9) begin
      time_codes[0] = qa[3:0];
    end else begin
      time_codes[0] = leading_zero ? 4'd0 : fdsm_pkg::CODE_BLANK;
    end
    time_codes[1] = ra[3:0];
    time_codes[2] = qb[3:0];
    time_codes[3] = rb[3:0];
  end

  assign err_codes[0] = fdsm_pkg::CODE_E;
  assign err_codes[1] = fdsm_pkg::CODE_R;
  assign err_codes[2] = fdsm_pkg::CODE_R;
  assign err_codes[3] = fdsm_pkg::CODE_BLANK;

  // Classify the item
  always_comb begin
    item.kind   = fdsm_pkg::KIND_NOP;
    item.codes  = err_codes;
    item.colon  = 1'b0;
    item.status = 1'b0;
    case (opcode)
      fdsm_pkg::OP_LOAD_INT: begin
        item.kind   = fdsm_pkg::KIND_LOAD;
        item.status = int_bad;
        item.codes  = int_bad ? err_codes : int_codes;
      end
      fdsm_pkg::OP_LOAD_TIME: begin
        item.kind   = fdsm_pkg::KIND_LOAD;
        item.status = time_bad;
        item.codes  = time_bad ? err_codes : time_codes;
        item.colon  = !time_bad;
      end
      fdsm_pkg::OP_TICK: begin
        item.kind = fdsm_pkg::KIND_TICK;
      end
      default: begin
        item.kind = fdsm_pkg::KIND_NOP;
      end
    endcase
  end

endmodule

### rtl/fdsm_queue.sv
module fdsm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = fdsm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = store[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count not advanced on push");

endmodule

### rtl/fdsm_back.sv
module fdsm_back #(
  parameter int HOLD_WIDTH = fdsm_pkg::HOLD_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   q_empty,
  input  fdsm_pkg::front_item_t  q_item,
  input  logic [HOLD_WIDTH-1:0]  q_hold,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [6:0]             segments,
  output logic                   colon,
  output logic [3:0]             digit_enable,
  output logic                   status
);

  logic [15:0]            dwell_ticks;
  logic                   driver_polarity;
  logic [3:0][3:0]        digit_codes;
  logic [3:0][3:0]        digit_codes_next;
  logic                   colon_shown;
  logic                   colon_shown_next;
  logic [1:0]             scan_position;
  logic [1:0]             scan_position_next;
  logic [15:0]            dwell_count;
  logic [15:0]            dwell_count_next;
  logic [HOLD_WIDTH-1:0]  hold_remaining;
  logic [HOLD_WIDTH-1:0]  hold_remaining_next;
  logic [6:0]             seg_next;
  logic                   colon_next;
  logic [3:0]             en_next;
  logic                   status_next;

  assign q_pop = !q_empty && (!out_valid || !out_stall);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks     <= 16'd1;
      driver_polarity <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        fdsm_pkg::REG_DWELL_TICKS:     dwell_ticks     <= cfg_data;
        fdsm_pkg::REG_DRIVER_POLARITY: driver_polarity <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Display state update and result for the item at the queue head
  always_comb begin
    logic [15:0]           dc;
    logic [HOLD_WIDTH-1:0] show_hold;
    logic [3:0][3:0]       show_codes;
    logic                  show_colon;
    logic [1:0]            show_pos;
    logic [3:0]            en;
    digit_codes_next    = digit_codes;
    colon_shown_next    = colon_shown;
    scan_position_next  = scan_position;
    dwell_count_next    = dwell_count;
    hold_remaining_next = hold_remaining;
    show_hold           = hold_remaining;
    show_codes          = digit_codes;
    show_colon          = colon_shown;
    show_pos            = scan_position;
    status_next         = 1'b0;
    dc                  = dwell_count + 16'd1;
    case (q_item.kind)
      fdsm_pkg::KIND_LOAD: begin
        digit_codes_next    = q_item.codes;
        colon_shown_next    = q_item.colon;
        hold_remaining_next = q_hold;
        scan_position_next  = 2'd0;
        dwell_count_next    = 16'd0;
        show_hold           = q_hold;
        show_codes          = q_item.codes;
        show_colon          = q_item.colon;
        show_pos            = 2'd0;
        status_next         = q_item.status;
      end
      fdsm_pkg::KIND_TICK: begin
        if (hold_remaining != '0) begin
          hold_remaining_next = hold_remaining - 1'b1;
          dwell_count_next    = dc;
          if (dc >= dwell_ticks || dc == 16'd0) begin
            dwell_count_next   = 16'd0;
            scan_position_next = scan_position + 2'd1;
          end
          if (hold_remaining == HOLD_WIDTH'(1)) begin
            digit_codes_next = {4{fdsm_pkg::CODE_BLANK}};
            colon_shown_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
    // Result at the configured polarity
    if (show_hold != '0) begin
      en         = 4'b0001 << show_pos;
      seg_next   = fdsm_pkg::seg_lookup(show_codes[show_pos]);
      colon_next = show_colon;
    end else begin
      en         = 4'b0000;
      seg_next   = 7'd0;
      colon_next = 1'b0;
    end
    en_next = driver_polarity ? en : ~en;
  end

  // Display state
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_codes    <= {4{fdsm_pkg::CODE_BLANK}};
      colon_shown    <= 1'b0;
      scan_position  <= 2'd0;
      dwell_count    <= 16'd0;
      hold_remaining <= '0;
    end else if (q_pop) begin
      digit_codes    <= digit_codes_next;
      colon_shown    <= colon_shown_next;
      scan_position  <= scan_position_next;
      dwell_count    <= dwell_count_next;
      hold_remaining <= hold_remaining_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      segments     <= seg_next;
      colon        <= colon_next;
      digit_enable <= en_next;
      status       <= status_next;
    end
  end

  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && driver_polarity) |-> $onehot0(digit_enable))
    else $error("more than one digit enabled");

  a_lit_has_digit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && segments != 7'd0) |->
      (digit_enable != (driver_polarity ? 4'b0000 : 4'b1111)))
    else $error("segments lit with no digit enabled");

  a_load_restarts_scan: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.kind == fdsm_pkg::KIND_LOAD) |=>
      (scan_position == 2'd0 && dwell_count == 16'd0))
    else $error("load did not restart the scan");

endmodule

### rtl/four_digit_segment_display_mux.sv
// An accepted item goes into the queue; the back end pops it and registers its result.
// Throughput: one item per cycle unless out_stall holds the output; an item is classified in
// the cycle it is accepted; the back end updates display state and registers a result on pop.
// Under output stall the queue keeps taking items until it is full, then in_stall rises.
// Reset (rst, synchronous): digits blank, colon off, scan and counters zero, queue empty,
// dwell_ticks 1, driver_polarity 1 (enables active high).
module four_digit_segment_display_mux #(
  parameter int HOLD_WIDTH  = fdsm_pkg::HOLD_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = fdsm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [14:0] number,
  input  logic               align_left,
  input  logic [6:0]         left_pair,
  input  logic [6:0]         right_pair,
  input  logic               leading_zero,
  input  logic [23:0]        hold_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         segments,
  output logic               colon,
  output logic [3:0]         digit_enable,
  output logic               status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int ENTRY_W = $bits(fdsm_pkg::front_item_t) + HOLD_WIDTH;

  fdsm_pkg::front_item_t  f_item;
  logic [HOLD_WIDTH-1:0]  f_hold;
  fdsm_pkg::front_item_t  q_item;
  logic [HOLD_WIDTH-1:0]  q_hold;
  logic [ENTRY_W-1:0]     q_out;
  logic                   q_full;
  logic                   q_empty;
  logic                   q_pop;
  logic                   push;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  fdsm_front #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_front (
    .opcode       (opcode),
    .number       (number),
    .align_left   (align_left),
    .left_pair    (left_pair),
    .right_pair   (right_pair),
    .leading_zero (leading_zero),
    .hold_ticks   (hold_ticks),
    .item         (f_item),
    .hold         (f_hold)
  );

  fdsm_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_item, f_hold}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign q_item = fdsm_pkg::front_item_t'(q_out[ENTRY_W-1:HOLD_WIDTH]);
  assign q_hold = q_out[HOLD_WIDTH-1:0];

  fdsm_back #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_empty      (q_empty),
    .q_item       (q_item),
    .q_hold       (q_hold),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .segments     (segments),
    .colon        (colon),
    .digit_enable (digit_enable),
    .status       (status)
  );

endmodule

### tb/sv/four_digit_segment_display_mux_tb.sv
module four_digit_segment_display_mux_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // opcode with no defined action
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 80;

  // segment patterns by digit code, code 15 first
  localparam logic [15:0][6:0] GLYPHS = {
    7'h00, 7'h00, 7'h18, 7'h3B, 7'h08, 7'h00, 7'h4F, 7'h7F,
    7'h46, 7'h7B, 7'h6B, 7'h4D, 7'h6E, 7'h3E, 7'h44, 7'h77
  };

  typedef struct {
    logic [1:0]         op;
    logic signed [14:0] number;
    logic               align_left;
    logic [6:0]         left_pair;
    logic [6:0]         right_pair;
    logic               leading_zero;
    logic [23:0]        hold;
  } disp_item_t;

  typedef struct packed {
    logic [6:0] segments;
    logic       colon;
    logic [3:0] digit_enable;
    logic       status;
  } scan_frame_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode = fdsm_pkg::OP_TICK;
  logic signed [14:0] number = '0;
  logic               align_left = 1'b0;
  logic [6:0]         left_pair = '0;
  logic [6:0]         right_pair = '0;
  logic               leading_zero = 1'b0;
  logic [23:0]        hold_ticks = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [6:0]         segments;
  logic               colon;
  logic [3:0]         digit_enable;
  logic               status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = fdsm_pkg::REG_DWELL_TICKS;
  logic [15:0]        cfg_data = '0;

  four_digit_segment_display_mux dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .number(number), .align_left(align_left),
    .left_pair(left_pair), .right_pair(right_pair),
    .leading_zero(leading_zero), .hold_ticks(hold_ticks),
    .out_valid(out_valid), .out_stall(out_stall),
    .segments(segments), .colon(colon), .digit_enable(digit_enable),
    .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted display state and register copies
  logic [3:0]  shown_codes [4];
  logic        shown_colon;
  logic [1:0]  scan_pos;
  logic [15:0] dwell_cnt;
  logic [23:0] hold_left;
  logic [15:0] dwell_cfg;
  logic        polarity_cfg;

  disp_item_t  items_to_send [$];
  scan_frame_t frames_due [$];
  disp_item_t  on_bus;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;
  int          cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void blank_display();
    for (int i = 0; i < 4; i++) shown_codes[i] = fdsm_pkg::CODE_BLANK;
    shown_colon = 1'b0;
  endfunction

  function automatic void latch_err();
    shown_codes[0] = fdsm_pkg::CODE_E;
    shown_codes[1] = fdsm_pkg::CODE_R;
    shown_codes[2] = fdsm_pkg::CODE_R;
    shown_codes[3] = fdsm_pkg::CODE_BLANK;
    shown_colon = 1'b0;
  endfunction

  function automatic void reset_display_model();
    blank_display();
    scan_pos = '0;
    dwell_cnt = '0;
    hold_left = '0;
    dwell_cfg = 16'd1;
    polarity_cfg = 1'b1;
  endfunction

  // frame for the current scan position
  function automatic scan_frame_t scan_out(input logic st);
    scan_frame_t r;
    logic [3:0] en;
    en = '0;
    r.segments = '0;
    r.colon = 1'b0;
    if (hold_left != 0) begin
      en = 4'b0001 << scan_pos;
      r.segments = GLYPHS[shown_codes[scan_pos]];
      r.colon = shown_colon;
    end
    r.digit_enable = polarity_cfg ? en : ~en;
    r.status = st;
    return r;
  endfunction

  function automatic logic load_number(input logic signed [14:0] value, input logic left);
    int v;
    int m;
    int first;
    int n;
    v = value;
    if (v > fdsm_pkg::INT_MAX || v < fdsm_pkg::INT_MIN) begin
      latch_err();
      return 1'b1;
    end
    blank_display();
    if (v < 0) begin
      shown_codes[0] = fdsm_pkg::CODE_MINUS;
      m = -v;
    end else begin
      m = v;
    end
    if (m == 0) begin
      shown_codes[3] = 4'd0;
    end else begin
      for (int i = 3; i >= 0 && m != 0; i--) begin
        shown_codes[i] = 4'(m % 10);
        m = m / 10;
      end
    end
    // left alignment squeezes out blanks after the sign
    if (left) begin
      first = (shown_codes[0] == fdsm_pkg::CODE_MINUS) ? 1 : 0;
      n = 0;
      while (n < 4 && shown_codes[first] == fdsm_pkg::CODE_BLANK) begin
        for (int i = first; i < 3; i++) shown_codes[i] = shown_codes[i + 1];
        shown_codes[3] = fdsm_pkg::CODE_BLANK;
        n++;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic load_clock(input logic [6:0] a, input logic [6:0] b,
                                      input logic lead);
    if (a > fdsm_pkg::PAIR_MAX || b > fdsm_pkg::PAIR_MAX) begin
      latch_err();
      return 1'b1;
    end
    if (a > 9) shown_codes[0] = 4'(a / 10);
    else shown_codes[0] = lead ? 4'd0 : fdsm_pkg::CODE_BLANK;
    shown_codes[1] = 4'(a % 10);
    shown_codes[2] = 4'(b / 10);
    shown_codes[3] = 4'(b % 10);
    shown_colon = 1'b1;
    return 1'b0;
  endfunction

  // frame caused by one item; advances the predicted state
  function automatic scan_frame_t predict_scan(input disp_item_t it);
    scan_frame_t r;
    logic st;
    case (it.op)
      fdsm_pkg::OP_LOAD_INT, fdsm_pkg::OP_LOAD_TIME: begin
        if (it.op == fdsm_pkg::OP_LOAD_INT) st = load_number(it.number, it.align_left);
        else st = load_clock(it.left_pair, it.right_pair, it.leading_zero);
        hold_left = it.hold;
        scan_pos = '0;
        dwell_cnt = '0;
        r = scan_out(st);
      end
      default: begin
        r = scan_out(1'b0);
        if (it.op == fdsm_pkg::OP_TICK && hold_left != 0) begin
          hold_left = hold_left - 1'b1;
          dwell_cnt = dwell_cnt + 1'b1;
          if (dwell_cnt >= dwell_cfg || dwell_cnt == 0) begin
            dwell_cnt = '0;
            scan_pos = scan_pos + 1'b1;
          end
          if (hold_left == 0) blank_display();
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- items

  function automatic disp_item_t noise_item();
    disp_item_t it;
    it.op = 2'($urandom);
    it.number = 15'($urandom);
    it.align_left = 1'($urandom);
    it.left_pair = 7'($urandom);
    it.right_pair = 7'($urandom);
    it.leading_zero = 1'($urandom);
    it.hold = 24'($urandom);
    return it;
  endfunction

  function automatic disp_item_t op_item(input logic [1:0] op);
    disp_item_t it;
    it = noise_item();
    it.op = op;
    return it;
  endfunction

  function automatic disp_item_t int_load(input int value, input logic left, input int hold);
    disp_item_t it;
    it = op_item(fdsm_pkg::OP_LOAD_INT);
    it.number = 15'(value);
    it.align_left = left;
    it.hold = 24'(hold);
    return it;
  endfunction

  function automatic disp_item_t time_load(input int a, input int b, input logic lead,
                                           input int hold);
    disp_item_t it;
    it = op_item(fdsm_pkg::OP_LOAD_TIME);
    it.left_pair = 7'(a);
    it.right_pair = 7'(b);
    it.leading_zero = lead;
    it.hold = 24'(hold);
    return it;
  endfunction

  function automatic int rand_hold();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 15) return int'(24'($urandom));
    return $urandom_range(1, 12);
  endfunction

  function automatic int rand_pair();
    if ($urandom_range(99) < 85) return $urandom_range(0, 99);
    return $urandom_range(0, 127);
  endfunction

  function automatic int rand_number();
    if ($urandom_range(99) < 85) return int'($urandom_range(0, 10998)) - 999;
    return int'(15'($urandom));
  endfunction

  // a load or a random item, followed by a run of ticks with some stray items
  task automatic add_sequence(output int added);
    int r;
    int k;
    r = $urandom_range(99);
    added = 1;
    if (r < 60) begin
      items_to_send.push_back(int_load(rand_number(), 1'($urandom), rand_hold()));
    end else if (r < 90) begin
      items_to_send.push_back(time_load(rand_pair(), rand_pair(), 1'($urandom),
                                        rand_hold()));
    end else begin
      items_to_send.push_back(noise_item());
    end
    k = $urandom_range(0, 14);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(99) < 5) begin
        items_to_send.push_back(op_item(OP_UNUSED));
      end else begin
        items_to_send.push_back(op_item(fdsm_pkg::OP_TICK));
        added++;
      end
    end
  endtask

  task automatic fill_items(input int n);
    int count;
    int added;
    count = 0;
    while (count < n) begin
      add_sequence(added);
      count += added;
    end
  endtask

  // idle means nothing queued, nothing on the bus and nothing outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (items_to_send.size() != 0 || in_valid || frames_due.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
    do @(negedge clk);
    while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == fdsm_pkg::REG_DWELL_TICKS) dwell_cfg = 16'(value);
    else polarity_cfg = value[0];
  endtask

  task automatic run_phase(input int unsigned dwell, input int unsigned pol,
                           input int idle, input int stall, input int n);
    wait_drained();
    write_reg(fdsm_pkg::REG_DWELL_TICKS, dwell);
    write_reg(fdsm_pkg::REG_DRIVER_POLARITY, pol);
    idle_pct = idle;
    stall_pct = stall;
    fill_items(n / 2);
    // sender holds off until the display has caught up
    wait_drained();
    fill_items(n - n / 2);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) frames_due.push_back(predict_scan(on_bus));
      if (!in_valid || !in_stall) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          on_bus = items_to_send.pop_front();
          in_valid <= 1'b1;
          opcode <= on_bus.op;
          number <= on_bus.number;
          align_left <= on_bus.align_left;
          left_pair <= on_bus.left_pair;
          right_pair <= on_bus.right_pair;
          leading_zero <= on_bus.leading_zero;
          hold_ticks <= on_bus.hold;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : monitor
    scan_frame_t got;
    scan_frame_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {segments, colon, digit_enable, status};
        if (frames_due.size() == 0) begin
          report($sformatf("item with none expected: %h", got));
        end else begin
          want = frames_due.pop_front();
          if (got.segments !== want.segments)
            report($sformatf("segments %h, expected %h", got.segments, want.segments));
          if (got.colon !== want.colon)
            report($sformatf("colon %b, expected %b", got.colon, want.colon));
          if (got.digit_enable !== want.digit_enable)
            report($sformatf("digit_enable %b, expected %b",
                             got.digit_enable, want.digit_enable));
          if (got.status !== want.status)
            report($sformatf("status %b, expected %b", got.status, want.status));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_display_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_reg(fdsm_pkg::REG_DWELL_TICKS, 1);
    write_reg(fdsm_pkg::REG_DRIVER_POLARITY, 1);

    // directed: dark display, unused opcode, extremes, errors, time forms
    items_to_send.push_back(op_item(fdsm_pkg::OP_TICK));
    items_to_send.push_back(op_item(OP_UNUSED));
    items_to_send.push_back(int_load(9999, 1'b0, 20));
    repeat (4) items_to_send.push_back(op_item(fdsm_pkg::OP_TICK));
    items_to_send.push_back(int_load(-999, 1'b1, 6));
    items_to_send.push_back(int_load(-5, 1'b1, 2));
    repeat (3) items_to_send.push_back(op_item(fdsm_pkg::OP_TICK));
    items_to_send.push_back(int_load(0, 1'b1, 3));
    items_to_send.push_back(int_load(7, 1'b0, 3));
    items_to_send.push_back(int_load(10000, 1'b0, 4));
    items_to_send.push_back(op_item(fdsm_pkg::OP_TICK));
    items_to_send.push_back(int_load(-1000, 1'b1, 4));
    items_to_send.push_back(int_load(16383, 1'b0, 5));
    items_to_send.push_back(int_load(-16384, 1'b1, 24'hFFFFFF));
    items_to_send.push_back(time_load(12, 34, 1'b0, 5));
    items_to_send.push_back(time_load(5, 7, 1'b0, 5));
    items_to_send.push_back(op_item(fdsm_pkg::OP_TICK));
    items_to_send.push_back(time_load(5, 7, 1'b1, 5));
    items_to_send.push_back(op_item(fdsm_pkg::OP_TICK));
    items_to_send.push_back(time_load(100, 0, 1'b0, 3));
    items_to_send.push_back(time_load(0, 127, 1'b1, 3));
    items_to_send.push_back(time_load(99, 99, 1'b0, 0));
    items_to_send.push_back(op_item(fdsm_pkg::OP_TICK));
    items_to_send.push_back(int_load(1234, 1'b1, 0));

    // random phases across register settings and handshake pressure
    run_phase(1, 1, 0, 0, PHASE_ITEMS);
    run_phase(3, 0, 49, 0, PHASE_ITEMS);
    run_phase(0, 1, 0, 49, PHASE_ITEMS);
    run_phase(65535, 0, 22, 22, PHASE_ITEMS);
    run_phase(4, 1, 0, 0, PHASE_ITEMS);

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/fdsm_pkg.sv
rtl/fdsm_front.sv
rtl/fdsm_queue.sv
rtl/fdsm_back.sv
rtl/four_digit_segment_display_mux.sv
tb/sv/four_digit_segment_display_mux_tb.sv
